// ===== rtl/core/circle_rasterizer_top_defines.svh =====
// ----------------------------------------------------------------------------
// circle rasterizer assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef CIRCLE_RASTERIZER_TOP_DEFINES_SVH
`define CIRCLE_RASTERIZER_TOP_DEFINES_SVH

// same-cycle implication
`define CR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cr_pkg.sv =====
// ----------------------------------------------------------------------------
// cr_pkg
// widths, register codes, types and helpers of the circle rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package cr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int CFG_COORD_W = 12;
  localparam int STEP_BITS   = COORD_BITS + 1;
  localparam int DEC_BITS    = COORD_BITS + 6;
  localparam int PIX_BITS    = 15;
  localparam int COLOR_BITS  = 24;
  localparam int ARITH_W     = (STEP_BITS > PIX_BITS) ? STEP_BITS : PIX_BITS;

  // squared distance and root widths
  localparam int SQ_W     = 2 * COORD_BITS + 1;
  localparam int ROOT_W   = COORD_BITS + 1;
  localparam int ROOT_T_W = 2 * ROOT_W;
  localparam int CNT_W    = $clog2(ROOT_W + 1);

  // bresenham constants
  localparam int DEC_INIT    = 3;
  localparam int DEC_INC_NEG = 6;
  localparam int DEC_INC_POS = 10;

  localparam logic [COLOR_BITS-1:0] COLOR_RESET = 24'hFF0000;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_RIM_X      = 3'd2,
    REG_RIM_Y      = 3'd3,
    REG_DRAW_COLOR = 3'd4
  } cr_reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ROOT
  } cr_state_t;

  typedef struct packed {
    logic [CFG_COORD_W-1:0] center_x;
    logic [CFG_COORD_W-1:0] center_y;
    logic [CFG_COORD_W-1:0] rim_x;
    logic [CFG_COORD_W-1:0] rim_y;
    logic [COLOR_BITS-1:0]  draw_color;
  } cr_cfg_t;

  typedef struct packed {
    logic load;
    logic advance;
  } cr_pix_ctrl_t;

  typedef struct packed {
    logic                valid;
    logic                last;
    logic [PIX_BITS-1:0] px;
    logic [PIX_BITS-1:0] py;
  } cr_pix_out_t;

  // register coordinate to the working coordinate width
  function automatic logic [COORD_BITS-1:0] coord_of(input logic [CFG_COORD_W-1:0] v);
    logic [CFG_COORD_W+COORD_BITS-1:0] ext;
    ext = {{COORD_BITS{1'b0}}, v};
    return ext[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cr_regs.sv =====
// ----------------------------------------------------------------------------
// cr_regs
// apb configuration registers: center, rim point and draw color
// ----------------------------------------------------------------------------
`default_nettype none

module cr_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cr_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [cr_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [cr_pkg::APB_DATA_W-1:0] prdata,
  output logic                               pready,
  output cr_pkg::cr_cfg_t                    cfg
);
  import cr_pkg::*;

  cr_cfg_t     cfg_r;
  cr_reg_idx_t idx;
  logic        wr_en;

  assign idx    = cr_reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x   <= '0;
      cfg_r.center_y   <= '0;
      cfg_r.rim_x      <= '0;
      cfg_r.rim_y      <= '0;
      cfg_r.draw_color <= COLOR_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_CENTER_X:   cfg_r.center_x   <= pwdata[CFG_COORD_W-1:0];
        REG_CENTER_Y:   cfg_r.center_y   <= pwdata[CFG_COORD_W-1:0];
        REG_RIM_X:      cfg_r.rim_x      <= pwdata[CFG_COORD_W-1:0];
        REG_RIM_Y:      cfg_r.rim_y      <= pwdata[CFG_COORD_W-1:0];
        REG_DRAW_COLOR: cfg_r.draw_color <= pwdata[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_CENTER_X:   prdata = APB_DATA_W'(cfg_r.center_x);
      REG_CENTER_Y:   prdata = APB_DATA_W'(cfg_r.center_y);
      REG_RIM_X:      prdata = APB_DATA_W'(cfg_r.rim_x);
      REG_RIM_Y:      prdata = APB_DATA_W'(cfg_r.rim_y);
      REG_DRAW_COLOR: prdata = APB_DATA_W'(cfg_r.draw_color);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/cr_sqrt.sv =====
// ----------------------------------------------------------------------------
// cr_sqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cr_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [cr_pkg::SQ_W-1:0]   radicand,
  output logic      [cr_pkg::ROOT_W-1:0] root,
  output logic                           done
);
  import cr_pkg::*;

  logic [SQ_W-1:0]     rem_r, rem_nxt;
  logic [ROOT_T_W-1:0] res_r, res_nxt;
  logic [ROOT_T_W-1:0] bit_r, bit_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [ROOT_T_W-1:0] trial;

  assign trial = res_r + bit_r;
  assign root  = res_r[ROOT_W-1:0];
  assign done  = done_r;

  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = radicand;
      res_nxt  = '0;
      bit_nxt  = ROOT_T_W'(1) << (ROOT_T_W - 2);
      cnt_nxt  = CNT_W'(ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ROOT_T_W'(rem_r) >= trial) begin
        rem_nxt = rem_r - trial[SQ_W-1:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/cr_pixel.sv =====
// ----------------------------------------------------------------------------
// cr_pixel
// bresenham step state and eight-way octant mirroring of the current point
// ----------------------------------------------------------------------------
`default_nettype none

module cr_pixel (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cr_pkg::cr_pix_ctrl_t          ctrl,
  input  wire logic [cr_pkg::ROOT_W-1:0]     root,
  input  wire logic [cr_pkg::COORD_BITS-1:0] cx,
  input  wire logic [cr_pkg::COORD_BITS-1:0] cy,
  output cr_pkg::cr_pix_out_t                pix
);
  import cr_pkg::*;

  logic [STEP_BITS-1:0] step_x_r, step_x_nxt;
  logic [STEP_BITS-1:0] step_y_r, step_y_nxt;
  logic [DEC_BITS-1:0]  dec_r, dec_nxt;
  logic [2:0]           oct_r, oct_nxt;
  logic                 drawing_r, drawing_nxt;

  logic [STEP_BITS-1:0] root_s;
  logic [STEP_BITS-1:0] vx, vy;
  logic [2:0]           voct;
  logic [ARITH_W-1:0]   ax, ay, acx, acy, sx, sy;
  logic [DEC_BITS-1:0]  xd, yd, dec_upd;
  logic signed [STEP_BITS+1:0] x_new, y_new;
  logic                 dec_neg, last_c, emit;

  assign root_s = STEP_BITS'(root);

  // during a load the view is the fresh point x=0, y=r
  assign vx   = ctrl.load ? '0 : step_x_r;
  assign vy   = ctrl.load ? root_s : step_y_r;
  assign voct = ctrl.load ? 3'd0 : oct_r;

  assign ax  = ARITH_W'(vx);
  assign ay  = ARITH_W'(vy);
  assign acx = ARITH_W'(cx);
  assign acy = ARITH_W'(cy);

  always_comb begin
    sx = acx + ax;
    sy = acy + ay;
    unique case (voct)
      3'd0: begin sx = acx + ax; sy = acy + ay; end
      3'd1: begin sx = acx - ax; sy = acy + ay; end
      3'd2: begin sx = acx + ax; sy = acy - ay; end
      3'd3: begin sx = acx - ax; sy = acy - ay; end
      3'd4: begin sx = acx + ay; sy = acy + ax; end
      3'd5: begin sx = acx - ay; sy = acy + ax; end
      3'd6: begin sx = acx + ay; sy = acy - ax; end
      3'd7: begin sx = acx - ay; sy = acy - ax; end
      default: ;
    endcase
  end

  // step to the next point, using x from before the increment
  assign dec_neg = dec_r[DEC_BITS-1];
  assign xd      = DEC_BITS'(step_x_r);
  assign yd      = DEC_BITS'(step_y_r);
  assign dec_upd = dec_neg ? dec_r + (xd << 2) + DEC_BITS'(DEC_INC_NEG)
                           : dec_r + ((xd - yd) << 2) + DEC_BITS'(DEC_INC_POS);
  assign x_new   = $signed({2'b00, step_x_r}) + (STEP_BITS+2)'(1);
  assign y_new   = dec_neg ? $signed({2'b00, step_y_r})
                           : $signed({2'b00, step_y_r}) - (STEP_BITS+2)'(1);
  assign last_c  = x_new > y_new;

  assign emit = ctrl.load | (ctrl.advance & drawing_r);

  always_comb begin
    pix.valid = emit;
    pix.last  = emit & ~ctrl.load & (oct_r == 3'd7) & last_c;
    pix.px    = emit ? sx[PIX_BITS-1:0] : '0;
    pix.py    = emit ? sy[PIX_BITS-1:0] : '0;
  end

  always_comb begin
    step_x_nxt  = step_x_r;
    step_y_nxt  = step_y_r;
    dec_nxt     = dec_r;
    oct_nxt     = oct_r;
    drawing_nxt = drawing_r;
    if (ctrl.load) begin
      step_x_nxt  = '0;
      step_y_nxt  = root_s;
      dec_nxt     = DEC_BITS'(DEC_INIT) - (DEC_BITS'(root_s) << 1);
      oct_nxt     = 3'd1;
      drawing_nxt = 1'b1;
    end else if (ctrl.advance && drawing_r) begin
      if (oct_r != 3'd7) begin
        oct_nxt = oct_r + 3'd1;
      end else begin
        step_x_nxt  = x_new[STEP_BITS-1:0];
        step_y_nxt  = y_new[STEP_BITS-1:0];
        dec_nxt     = dec_upd;
        oct_nxt     = 3'd0;
        drawing_nxt = ~last_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r  <= '0;
      step_y_r  <= '0;
      dec_r     <= '0;
      oct_r     <= '0;
      drawing_r <= 1'b0;
    end else begin
      step_x_r  <= step_x_nxt;
      step_y_r  <= step_y_nxt;
      dec_r     <= dec_nxt;
      oct_r     <= oct_nxt;
      drawing_r <= drawing_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/circle_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// circle_rasterizer_top
// bresenham circle generator with apb configuration, one pixel per transaction
// ----------------------------------------------------------------------------
// usage:
//   configure center, rim point and color over the apb port while idle.
//   each input transaction carries restart. restart=1 squares dx and dy on
//   one shared multiplier, then runs the iterative root unit, one root bit
//   per cycle, and emits the first pixel into the output register; in_ready
//   stays low meanwhile.
//   restart=0 emits the next mirrored pixel in the cycle after acceptance,
//   so pixels stream at one per cycle while out_ready stays high; after the
//   last pixel (last_pixel=1) results carry pixel_valid=0 until the next restart.
//   the result sits in an output register; a new transaction is taken in the
//   same cycle that the pending result is taken. while out_ready is low and
//   a result is pending, in_ready is low.
//   reset (synchronous, rst_n low) clears the sequencer, drops any circle and
//   loads register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "circle_rasterizer_top_defines.svh"

module circle_rasterizer_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_restart,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [cr_pkg::PIX_BITS-1:0]       out_pixel_x,
  output logic signed [cr_pkg::PIX_BITS-1:0]       out_pixel_y,
  output logic        [cr_pkg::COLOR_BITS-1:0]     out_pixel_color,
  output logic                                     out_pixel_valid,
  output logic                                     out_last_pixel,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic   [cr_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic   [cr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic        [cr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);
  import cr_pkg::*;

  cr_cfg_t      cfg;
  cr_state_t    state_r, state_nxt;
  cr_pix_ctrl_t pctrl;
  cr_pix_out_t  pix;

  logic [COORD_BITS-1:0]   cx, cy, rx, ry, mag_x, mag_y, mul_op;
  logic signed [COORD_BITS:0] dx, dy;
  logic [2*COORD_BITS-1:0] prod;
  logic [SQ_W-1:0]         acc_r, acc_nxt;
  logic [ROOT_W-1:0]       root;
  logic                    root_done, root_start;
  logic                    in_acc, out_load;

  logic                    out_valid_r, out_valid_nxt;
  logic [PIX_BITS-1:0]     out_px_r, out_py_r;
  logic [COLOR_BITS-1:0]   out_color_r;
  logic                    out_pvalid_r, out_last_r;

  cr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign cx = coord_of(cfg.center_x);
  assign cy = coord_of(cfg.center_y);
  assign rx = coord_of(cfg.rim_x);
  assign ry = coord_of(cfg.rim_y);

  assign dx    = $signed({1'b0, cx}) - $signed({1'b0, rx});
  assign dy    = $signed({1'b0, cy}) - $signed({1'b0, ry});
  assign mag_x = COORD_BITS'(dx[COORD_BITS] ? -dx : dx);
  assign mag_y = COORD_BITS'(dy[COORD_BITS] ? -dy : dy);

  // one multiplier squares dx then dy
  assign mul_op  = (state_r == ST_SQY) ? mag_y : mag_x;
  assign prod    = mul_op * mul_op;
  assign acc_nxt = (state_r == ST_SQY) ? acc_r + SQ_W'(prod) : SQ_W'(prod);

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign root_start = (state_r == ST_SQY);

  cr_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (acc_nxt),
    .root     (root),
    .done     (root_done)
  );

  cr_pixel u_pixel (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (pctrl),
    .root  (root),
    .cx    (cx),
    .cy    (cy),
    .pix   (pix)
  );

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    pctrl.load    = 1'b0;
    pctrl.advance = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_restart) begin
            state_nxt = ST_SQX;
          end else begin
            pctrl.advance = 1'b1;
          end
        end
      end
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (root_done) begin
          pctrl.load = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register
  assign out_load      = pctrl.load | pctrl.advance;
  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_px_r     <= pix.px;
      out_py_r     <= pix.py;
      out_color_r  <= pix.valid ? cfg.draw_color : '0;
      out_pvalid_r <= pix.valid;
      out_last_r   <= pix.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = $signed(out_px_r);
  assign out_pixel_y     = $signed(out_py_r);
  assign out_pixel_color = out_color_r;
  assign out_pixel_valid = out_pvalid_r;
  assign out_last_pixel  = out_last_r;

  `CR_ASSERT_SAME(a_busy_not_ready, state_r != ST_IDLE, !in_ready, "ready while computing radius")
  `CR_ASSERT_NEXT(a_restart_starts, in_acc && in_restart, state_r == ST_SQX,
                  "restart did not start the squaring")
  `CR_ASSERT_SAME(a_load_slot_free, state_r == ST_ROOT && root_done, !out_valid_r,
                  "first pixel would overwrite a pending transaction")
  `CR_ASSERT_NEXT(a_load_emits, state_r == ST_ROOT && root_done,
                  state_r == ST_IDLE && out_valid_r && out_pvalid_r && !out_last_r,
                  "first pixel of a circle not presented")

endmodule

`default_nettype wire

// ===== tb/tb_circle_rasterizer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circle_rasterizer_top
// drives restart and advance transactions into the circle rasterizer while
// an in-bench shadow of the midpoint circle sequencer predicts every pixel;
// results are compared field by field as they arrive, under random sender
// gaps, receiver stalls, a long output hold-off and apb register updates
// ----------------------------------------------------------------------------

module tb_circle_rasterizer_top;
  import cr_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 200;
  localparam int RANDOM_TICKS  = 330;
  localparam int SETTLE_CYCLES = COORD_BITS + 8;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_TOGGLE,
    RX_SPARSE
  } rx_mode_t;

  typedef struct {
    logic signed [PIX_BITS-1:0] x;
    logic signed [PIX_BITS-1:0] y;
    logic [COLOR_BITS-1:0]      color;
    logic                       valid;
    logic                       last;
  } pixel_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_restart;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [PIX_BITS-1:0]  out_pixel_x;
  logic signed [PIX_BITS-1:0]  out_pixel_y;
  logic [COLOR_BITS-1:0]       out_pixel_color;
  logic                        out_pixel_valid;
  logic                        out_last_pixel;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [APB_ADDR_W-1:0]       paddr;
  logic [APB_DATA_W-1:0]       pwdata;
  logic [APB_DATA_W-1:0]       prdata;
  logic                        pready;

  // shadow copy of the registers and the sequencer
  logic [COORD_BITS-1:0]       center_x_q;
  logic [COORD_BITS-1:0]       center_y_q;
  logic [COORD_BITS-1:0]       rim_x_q;
  logic [COORD_BITS-1:0]       rim_y_q;
  logic [COLOR_BITS-1:0]       color_q;
  logic [STEP_BITS-1:0]        arc_x;
  logic [STEP_BITS-1:0]        arc_y;
  logic signed [DEC_BITS-1:0]  arc_err;
  logic [2:0]                  octant;
  logic                        drawing;

  pixel_t pixels_due[$];

  int       errors        = 0;
  int       burst_left    = 0;
  bit       sender_steady = 1'b0;
  int       busy_ticks    = 0;
  int       hold_asked    = 0;
  int       hold_taken    = 0;
  int       hold_left     = 0;
  int       rx_tick       = 0;
  rx_mode_t rx_mode       = RX_ALWAYS;
  int       cycle_count   = 0;

  circle_rasterizer_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_pixel_valid (out_pixel_valid),
    .out_last_pixel  (out_last_pixel),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned floor_sqrt(input int unsigned n);
    int unsigned root;
    int unsigned probe;
    root  = 0;
    probe = 1 << 30;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // one of the eight symmetric points of the current arc position
  function automatic pixel_t mirrored_pixel(input logic last);
    pixel_t p;
    int cx;
    int cy;
    int ax;
    int ay;
    int px;
    int py;
    cx = int'(center_x_q);
    cy = int'(center_y_q);
    ax = int'(arc_x);
    ay = int'(arc_y);
    case (octant)
      3'd0: begin px = cx + ax; py = cy + ay; end
      3'd1: begin px = cx - ax; py = cy + ay; end
      3'd2: begin px = cx + ax; py = cy - ay; end
      3'd3: begin px = cx - ax; py = cy - ay; end
      3'd4: begin px = cx + ay; py = cy + ax; end
      3'd5: begin px = cx - ay; py = cy + ax; end
      3'd6: begin px = cx + ay; py = cy - ax; end
      default: begin px = cx - ay; py = cy - ax; end
    endcase
    p.x     = PIX_BITS'(px);
    p.y     = PIX_BITS'(py);
    p.color = color_q;
    p.valid = 1'b1;
    p.last  = last;
    return p;
  endfunction

  function automatic void raster_step(input logic restart);
    pixel_t p;
    int     dx;
    int     dy;
    int     nx;
    int     ny;
    int     nd;
    logic   last;
    if (restart) begin
      dx      = int'(center_x_q) - int'(rim_x_q);
      dy      = int'(center_y_q) - int'(rim_y_q);
      arc_x   = '0;
      arc_y   = STEP_BITS'(floor_sqrt(dx * dx + dy * dy));
      arc_err = DEC_BITS'(DEC_INIT - 2 * int'(arc_y));
      octant  = 3'd0;
      drawing = 1'b1;
      p       = mirrored_pixel(1'b0);
      octant  = 3'd1;
    end else if (!drawing) begin
      p = '{default: '0};
    end else if (octant != 3'd7) begin
      p      = mirrored_pixel(1'b0);
      octant = octant + 3'd1;
    end else begin
      // eighth point still uses the old position, then the midpoint update
      nx = int'(arc_x);
      ny = int'(arc_y);
      nd = int'(arc_err);
      if (nd < 0) begin
        nd += 4 * nx + DEC_INC_NEG;
      end else begin
        nd += 4 * (nx - ny) + DEC_INC_POS;
        ny -= 1;
      end
      nx     += 1;
      last    = nx > ny;
      p       = mirrored_pixel(last);
      arc_x   = STEP_BITS'(nx);
      arc_y   = STEP_BITS'(ny);
      arc_err = DEC_BITS'(nd);
      octant  = 3'd0;
      if (last) drawing = 1'b0;
    end
    pixels_due.push_back(p);
  endfunction

  task automatic send_tick(input logic restart);
    int gap;
    if (!sender_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap        = $urandom_range(1, 6);
        in_valid  <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    if (restart || drawing) busy_ticks++;
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    raster_step(restart);
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cr_reg_idx_t idx, input logic [APB_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_CENTER_X:   center_x_q = data[COORD_BITS-1:0];
      REG_CENTER_Y:   center_y_q = data[COORD_BITS-1:0];
      REG_RIM_X:      rim_x_q    = data[COORD_BITS-1:0];
      REG_RIM_Y:      rim_y_q    = data[COORD_BITS-1:0];
      REG_DRAW_COLOR: color_q    = data[COLOR_BITS-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // advance ticks before any circle give empty results
  task automatic test_idle_ticks();
    repeat (2) send_tick(1'b0);
  endtask

  // reset registers put the rim on the center
  task automatic test_zero_radius();
    send_tick(1'b1);
    repeat (8) send_tick(1'b0);
  endtask

  // largest radius, then a restart that drops it at the opposite corner
  task automatic test_extreme_coords();
    drain_pixels();
    write_reg(REG_CENTER_X, 32'hFFFF_FFFF);
    write_reg(REG_CENTER_Y, 32'hFFFF_FFFF);
    write_reg(REG_RIM_X, 32'h0000_0000);
    write_reg(REG_RIM_Y, 32'h0000_0000);
    write_reg(REG_DRAW_COLOR, 32'hFFFF_FFFF);
    send_tick(1'b1);
    repeat (9) send_tick(1'b0);
    drain_pixels();
    write_reg(REG_CENTER_X, 32'hFFFF_F000);
    write_reg(REG_CENTER_Y, 32'hFFFF_F000);
    write_reg(REG_RIM_X, 32'h0000_0FFF);
    write_reg(REG_RIM_Y, 32'h0000_0FFF);
    write_reg(REG_DRAW_COLOR, 32'hFF00_0000);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
  endtask

  task automatic test_color_change();
    drain_pixels();
    write_reg(REG_CENTER_X, 32'd2048);
    write_reg(REG_CENTER_Y, 32'd1024);
    write_reg(REG_RIM_X, 32'd2049);
    write_reg(REG_RIM_Y, 32'd1024);
    write_reg(REG_DRAW_COLOR, $urandom());
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    drain_pixels();
    write_reg(REG_DRAW_COLOR, $urandom());
    repeat (5) send_tick(1'b0);
  endtask

  // output held off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    drain_pixels();
    write_reg(REG_CENTER_X, 32'd1000);
    write_reg(REG_CENTER_Y, 32'd3000);
    write_reg(REG_RIM_X, 32'd1010);
    write_reg(REG_RIM_Y, 32'd3000);
    write_reg(REG_DRAW_COLOR, $urandom());
    sender_steady = 1'b1;
    hold_asked++;
    send_tick(1'b1);
    repeat (60) send_tick(1'b0);
    sender_steady = 1'b0;
  endtask

  task automatic test_random_circles();
    int start;
    int cx;
    int cy;
    int rx;
    int ry;
    int span;
    start = busy_ticks;
    while (busy_ticks - start < RANDOM_TICKS) begin
      drain_pixels();
      sender_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) != 0) begin
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
        if ($urandom_range(0, 5) == 0) cx = $urandom_range(0, 1) ? 4095 : 0;
        if ($urandom_range(0, 5) == 0) cy = $urandom_range(0, 1) ? 4095 : 0;
        span = ($urandom_range(0, 9) == 0) ? 40 : 12;
        rx = cx + $urandom_range(0, 2 * span) - span;
        ry = cy + $urandom_range(0, 2 * span) - span;
        rx = (rx < 0) ? 0 : ((rx > 4095) ? 4095 : rx);
        ry = (ry < 0) ? 0 : ((ry > 4095) ? 4095 : ry);
        write_reg(REG_CENTER_X, ($urandom() & 32'hFFFF_F000) | cx);
        write_reg(REG_CENTER_Y, ($urandom() & 32'hFFFF_F000) | cy);
        write_reg(REG_RIM_X, ($urandom() & 32'hFFFF_F000) | rx);
        write_reg(REG_RIM_Y, ($urandom() & 32'hFFFF_F000) | ry);
        write_reg(REG_DRAW_COLOR, $urandom());
        send_tick(1'b1);
      end
      // now and then a circle is abandoned before its last pixel
      while (drawing && $urandom_range(0, 59) != 0) send_tick(1'b0);
      repeat ($urandom_range(0, 3)) send_tick($urandom_range(0, 5) == 0);
      sender_steady = 1'b0;
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_restart = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    center_x_q = '0;
    center_y_q = '0;
    rim_x_q    = '0;
    rim_y_q    = '0;
    color_q    = COLOR_RESET;
    arc_x      = '0;
    arc_y      = '0;
    arc_err    = '0;
    octant     = 3'd0;
    drawing    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_ticks();
    test_zero_radius();
    test_extreme_coords();
    test_color_change();
    test_backpressure();
    test_random_circles();
    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_circle_rasterizer_top passed");
    end else begin
      $display("tb_circle_rasterizer_top failed");
    end
    $finish;
  end

  // receiver: random stall modes, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      out_ready  <= 1'b0;
      hold_taken <= hold_taken + 1;
      hold_left  <= HOLD_CYCLES;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_tick[5:0] == 6'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        RX_TOGGLE: out_ready <= rx_tick[1];
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual x=%0d y=%0d valid=%0b",
                 $time, out_pixel_x, out_pixel_y, out_pixel_valid);
        errors++;
      end else begin
        want = pixels_due.pop_front();
        check_field("pixel_x", want.x, out_pixel_x);
        check_field("pixel_y", want.y, out_pixel_y);
        check_field("pixel_color", want.color, out_pixel_color);
        check_field("pixel_valid", want.valid, out_pixel_valid);
        check_field("last_pixel", want.last, out_last_pixel);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_circle_rasterizer_top failed");
      $finish;
    end
  end

endmodule
